>>> sv/deque_bag_table_macros.svh
// assertion macros shared by the deque bag table rtl
// no dependencies; pulled in by files that carry concurrent checks
`ifndef DEQUE_BAG_TABLE_MACROS_SVH
`define DEQUE_BAG_TABLE_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define DBT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dbt check failed: same-cycle implication");

// next-cycle implication under synchronous active-low reset
`define DBT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dbt check failed: next-cycle implication");

`endif

>>> sv/dbt_pkg.sv
// types and codes for the deque bag table
// no dependencies; used by dbt_cell and deque_bag_table
`timescale 1ns / 1ps

package dbt_pkg;

    // request codes; the two unused codes act as no operation
    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_CONTAINS   = 3'd4;
    localparam logic [2:0] REQ_REMOVE     = 3'd5;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_TAKE_PREV,
        CELL_TAKE_NEXT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     capture;
        logic     occupied;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REPORT
    } t_state;

endpackage

>>> sv/dbt_cell.sv
// one storage cell of the deque bag table chain
// depends on dbt_pkg for the cell control struct
`timescale 1ns / 1ps

module dbt_cell
    import dbt_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctl             i_ctl,
    input  logic [DATA_WIDTH-1:0] i_prev_data,
    input  logic [DATA_WIDTH-1:0] i_next_data,
    input  logic [DATA_WIDTH-1:0] i_load_data,
    input  logic [DATA_WIDTH-1:0] i_cmp_data,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_hit
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  r_hit;
    logic                  n_hit;

    always_comb begin
        unique case (i_ctl.op)
            CELL_HOLD:      n_data = r_data;
            CELL_LOAD:      n_data = i_load_data;
            CELL_TAKE_PREV: n_data = i_prev_data;
            CELL_TAKE_NEXT: n_data = i_next_data;
        endcase
    end

    // match flag only counts for a live entry
    assign n_hit = i_ctl.capture ? (i_ctl.occupied && (r_data == i_cmp_data)) : r_hit;

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= n_hit;
        end
    end

    assign o_data = r_data;
    assign o_hit  = r_hit;

endmodule

>>> sv/deque_bag_table.sv
// deque bag table top level: a chain of dbt_cell storage cells plus a three-step sequencer
// depends on dbt_pkg, dbt_cell and deque_bag_table_macros.svh
// result path: the match is compared on the accepting edge, then the update step, then the
// report step loads the result register
// one transaction at a time: a new one is taken only once the last leaves the report step;
// a result still waiting in the output register holds the sequencer in the report step
// reset: synchronous active low; clears the entry count, sequencer and output valid
`timescale 1ns / 1ps

`include "deque_bag_table_macros.svh"

module deque_bag_table
    import dbt_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_req_type,
    input  logic signed [31:0] i_value,
    // result channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_found,
    output logic signed [31:0] o_front_value,
    output logic signed [31:0] o_back_value,
    output logic [4:0]         o_entry_count,
    output logic               o_is_empty,
    output logic [1:0]         o_status
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // sequencer
    t_state r_state;
    t_state n_state;
    logic   w_capture;   // request transaction this cycle, cells latch their match
    logic   w_exec;      // cells shift / load and the count moves
    logic   w_load;      // result register takes the report

    // request held between capture and update
    logic [2:0]            r_req;
    logic [DATA_WIDTH-1:0] r_value;
    logic [DATA_WIDTH-1:0] w_in_value;

    // store occupancy
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             w_full;
    logic             w_empty;

    // chain wiring
    logic [DATA_WIDTH-1:0] w_data [DEPTH];
    logic [DATA_WIDTH-1:0] w_prev [DEPTH];
    logic [DATA_WIDTH-1:0] w_next [DEPTH];
    logic [DEPTH-1:0]      w_hit;
    logic [DEPTH-1:0]      w_ge_mask;
    logic                  w_hit_any;

    // update results carried into the report step
    logic    w_found;
    t_status w_status;
    logic    r_found;
    t_status r_status;

    // report
    logic [DATA_WIDTH-1:0] w_front;
    logic [DATA_WIDTH-1:0] w_back;

    // result register
    logic               r_out_valid;
    logic               r_out_found;
    logic signed [31:0] r_out_front;
    logic signed [31:0] r_out_back;
    logic [4:0]         r_out_count;
    logic               r_out_empty;
    logic [1:0]         r_out_status;

    // values are kept as the low DATA_WIDTH bits of the request value
    assign w_in_value = DATA_WIDTH'(i_value);

    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    // ---------------------------------------------------------------
    // sequencer: idle (take a transaction), exec (update), report
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_ready   = 1'b0;
        w_capture = 1'b0;
        w_exec    = 1'b0;
        w_load    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // a finished result may still wait in the output register here
                o_ready = 1'b1;
                if (i_valid) begin
                    w_capture = 1'b1;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                w_exec  = 1'b1;
                n_state = S_REPORT;
            end
            S_REPORT: begin
                if (!r_out_valid || i_ready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_capture) begin
            r_req   <= i_req_type;
            r_value <= w_in_value;
        end
    end

    // ---------------------------------------------------------------
    // first-match location: every cell at or behind the first hit
    // closes the gap on a removal
    // ---------------------------------------------------------------
    assign w_hit_any = |w_hit;
    assign w_ge_mask = ~((w_hit - DEPTH'(1)) & ~w_hit);

    // ---------------------------------------------------------------
    // cell chain: entry 0 is the front, entry count-1 the back
    // ---------------------------------------------------------------
    genvar gi;
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_cell_ctl w_ctl;

        if (gi == 0) begin : g_head
            assign w_prev[gi] = '0;
        end else begin : g_body
            assign w_prev[gi] = w_data[gi-1];
        end

        // the tail cell has no neighbor behind it and keeps its own data
        if (gi == DEPTH - 1) begin : g_tail
            assign w_next[gi] = w_data[gi];
        end else begin : g_inner
            assign w_next[gi] = w_data[gi+1];
        end

        always_comb begin
            w_ctl.capture  = w_capture;
            w_ctl.occupied = (CNT_W'(gi) < r_count);
            w_ctl.op       = CELL_HOLD;
            if (w_exec) begin
                unique case (r_req)
                    REQ_PUSH_FRONT: begin
                        // everything moves back one place, the head takes the value
                        if (!w_full) begin
                            w_ctl.op = (gi == 0) ? CELL_LOAD : CELL_TAKE_PREV;
                        end
                    end
                    REQ_PUSH_BACK: begin
                        if (!w_full && (CNT_W'(gi) == r_count)) begin
                            w_ctl.op = CELL_LOAD;
                        end
                    end
                    REQ_POP_FRONT: begin
                        if (!w_empty) begin
                            w_ctl.op = CELL_TAKE_NEXT;
                        end
                    end
                    REQ_REMOVE: begin
                        if (w_hit_any && w_ge_mask[gi]) begin
                            w_ctl.op = CELL_TAKE_NEXT;
                        end
                    end
                    default: begin
                        // pop back, contains and unused codes leave the data alone
                        w_ctl.op = CELL_HOLD;
                    end
                endcase
            end
        end

        dbt_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_prev_data (w_prev[gi]),
            .i_next_data (w_next[gi]),
            .i_load_data (r_value),
            .i_cmp_data  (w_in_value),
            .o_data      (w_data[gi]),
            .o_hit       (w_hit[gi])
        );
    end

    // ---------------------------------------------------------------
    // count, status and found for the update step
    // ---------------------------------------------------------------
    always_comb begin
        n_count  = r_count;
        w_status = ST_OK;
        w_found  = 1'b0;
        if (w_exec) begin
            unique case (r_req)
                REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                    if (w_full) begin
                        w_status = ST_PUSH_FULL;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
                REQ_POP_FRONT, REQ_POP_BACK: begin
                    if (w_empty) begin
                        w_status = ST_POP_EMPTY;
                    end else begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
                REQ_CONTAINS: begin
                    w_found = w_hit_any;
                end
                REQ_REMOVE: begin
                    // hits only come from live entries, so an empty store finds nothing
                    w_found = w_hit_any;
                    if (w_hit_any) begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
                default: begin
                    w_found = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_found  <= w_found;
            r_status <= w_status;
        end
    end

    // ---------------------------------------------------------------
    // report: front is the head cell, back is the cell at count-1
    // ---------------------------------------------------------------
    assign w_front = w_empty ? '0 : w_data[0];

    always_comb begin
        w_back = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if ((CNT_W'(i) + CNT_W'(1)) == r_count) begin
                w_back = w_back | w_data[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_found  <= r_found;
            r_out_front  <= 32'(w_front);
            r_out_back   <= 32'(w_back);
            r_out_count  <= 5'(r_count);
            r_out_empty  <= w_empty;
            r_out_status <= r_status;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_found       = r_out_found;
    assign o_front_value = r_out_front;
    assign o_back_value  = r_out_back;
    assign o_entry_count = r_out_count;
    assign o_is_empty    = r_out_empty;
    assign o_status      = r_out_status;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    // occupancy never passes the number of cells
    `DBT_ASSERT_IMPLIES(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    // the count moves only in the update step
    `DBT_ASSERT_NEXT(a_count_only_exec, i_clk, i_rst_n,
        r_state != S_EXEC, r_count == $past(r_count))
    // a rejected push or pop leaves the occupancy alone
    `DBT_ASSERT_NEXT(a_error_no_change, i_clk, i_rst_n,
        (r_state == S_EXEC) && (w_status != ST_OK), r_count == $past(r_count))
    // a result only appears from the report step
    `DBT_ASSERT_IMPLIES(a_valid_from_report, i_clk, i_rst_n,
        $rose(r_out_valid), $past(r_state) == S_REPORT)

endmodule

>>> tb/dbt_result_checker.sv
// result checker for the deque bag table: watches both channels, predicts and compares
// depends on dbt_pkg; instantiated by testbench beside the block
`timescale 1ns / 1ps

module dbt_result_checker
    import dbt_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [2:0]  i_req_type,
    input  logic [31:0] i_req_value,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic        i_found,
    input  logic [31:0] i_front_value,
    input  logic [31:0] i_back_value,
    input  logic [4:0]  i_entry_count,
    input  logic        i_is_empty,
    input  logic [1:0]  i_status,
    output int          o_mismatches,
    output int          o_outstanding
);

    typedef struct packed {
        logic        found;
        logic [31:0] front;
        logic [31:0] back;
        logic [4:0]  count;
        logic        empty;
        t_status     status;
    } t_outcome;

    logic [31:0] shadow [DEPTH];
    int          shadow_cnt;
    int          mismatch_cnt;
    t_outcome    outcome_q [$];

    // applies one request to the shadow store and returns what the block should report
    function automatic t_outcome apply_request(input logic [2:0] req, input logic [31:0] val);
        t_outcome res;
        int       k;
        int       pos;
        res        = '0;
        res.status = ST_OK;
        pos        = -1;
        case (req)
            REQ_PUSH_FRONT: begin
                if (shadow_cnt >= DEPTH) begin
                    res.status = ST_PUSH_FULL;
                end else begin
                    for (k = shadow_cnt; k > 0; k--)
                        shadow[k] = shadow[k - 1];
                    shadow[0] = val;
                    shadow_cnt++;
                end
            end
            REQ_PUSH_BACK: begin
                if (shadow_cnt >= DEPTH) begin
                    res.status = ST_PUSH_FULL;
                end else begin
                    shadow[shadow_cnt] = val;
                    shadow_cnt++;
                end
            end
            REQ_POP_FRONT: begin
                if (shadow_cnt == 0) begin
                    res.status = ST_POP_EMPTY;
                end else begin
                    for (k = 0; k + 1 < shadow_cnt; k++)
                        shadow[k] = shadow[k + 1];
                    shadow_cnt--;
                end
            end
            REQ_POP_BACK: begin
                if (shadow_cnt == 0)
                    res.status = ST_POP_EMPTY;
                else
                    shadow_cnt--;
            end
            REQ_CONTAINS, REQ_REMOVE: begin
                for (k = 0; k < shadow_cnt; k++)
                    if (pos < 0 && shadow[k] == val)
                        pos = k;
                res.found = (pos >= 0);
                if (req == REQ_REMOVE && pos >= 0) begin
                    for (k = pos; k + 1 < shadow_cnt; k++)
                        shadow[k] = shadow[k + 1];
                    shadow_cnt--;
                end
            end
            default: begin
                // unused codes leave the store alone
            end
        endcase
        res.front = (shadow_cnt != 0) ? shadow[0] : 32'd0;
        res.back  = (shadow_cnt != 0) ? shadow[shadow_cnt - 1] : 32'd0;
        res.count = shadow_cnt[4:0];
        res.empty = (shadow_cnt == 0);
        return res;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t: mismatch in %s: got %h, wanted %h", $time, what, got, want);
        mismatch_cnt++;
    endtask

    task automatic check_result();
        t_outcome want;
        if (outcome_q.size() == 0) begin
            note_mismatch("result with no request outstanding", 32'd0, 32'd0);
            return;
        end
        want = outcome_q.pop_front();
        if (i_found !== want.found)
            note_mismatch("found", 32'(i_found), 32'(want.found));
        if (i_front_value !== want.front)
            note_mismatch("front_value", i_front_value, want.front);
        if (i_back_value !== want.back)
            note_mismatch("back_value", i_back_value, want.back);
        if (i_entry_count !== want.count)
            note_mismatch("entry_count", 32'(i_entry_count), 32'(want.count));
        if (i_is_empty !== want.empty)
            note_mismatch("is_empty", 32'(i_is_empty), 32'(want.empty));
        if (i_status !== want.status)
            note_mismatch("status", 32'(i_status), 32'(want.status));
    endtask

    initial mismatch_cnt = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_cnt = 0;
            outcome_q.delete();
        end else begin
            if (i_res_valid && i_res_ready)
                check_result();
            if (i_req_valid && i_req_ready)
                outcome_q.push_back(apply_request(i_req_type, i_req_value));
        end
        o_outstanding <= outcome_q.size();
        o_mismatches  <= mismatch_cnt;
    end

endmodule

>>> tb/testbench.sv
// top of the deque bag table testbench: clock, reset, request and result traffic, verdict
// depends on dbt_pkg, deque_bag_table and dbt_result_checker
`timescale 1ns / 1ps

module testbench;
    import dbt_pkg::*;

    // request codes the block treats as no operation
    localparam logic [2:0] REQ_NOP_LO = 3'd6;
    localparam logic [2:0] REQ_NOP_HI = 3'd7;

    localparam int HOLD_CYCLES  = 64;  // long receiver hold-off, enough to back up the block
    localparam int DRAIN_TAIL   = 12;  // idle tail after the last result, before the verdict
    localparam int PHASE_ITEMS  = 200;
    localparam int BIAS_BLOCK   = 40;  // items per fill or drain leaning stretch

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic [2:0]  i_req_type = REQ_NOP_LO;
    logic [31:0] i_value    = 32'd0;
    logic        i_ready    = 1'b0;

    logic        o_ready;
    logic        o_valid;
    logic        o_found;
    logic [31:0] o_front_value;
    logic [31:0] o_back_value;
    logic [4:0]  o_entry_count;
    logic        o_is_empty;
    logic [1:0]  o_status;

    int          mismatches;
    int          outstanding;

    // idle odds in percent; the sender's is only touched by the stimulus process
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    // flipping this asks the result sink for one long hold-off
    logic        hold_flip   = 1'b0;

    // small pool so that searches and removals hit often, duplicates included
    logic [31:0] value_pool [8];

    deque_bag_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_found       (o_found),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty),
        .o_status      (o_status)
    );

    dbt_result_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_ready   (o_ready),
        .i_req_type    (i_req_type),
        .i_req_value   (i_value),
        .i_res_valid   (o_valid),
        .i_res_ready   (i_ready),
        .i_found       (o_found),
        .i_front_value (o_front_value),
        .i_back_value  (o_back_value),
        .i_entry_count (o_entry_count),
        .i_is_empty    (o_is_empty),
        .i_status      (o_status),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // result side: random ready, plus one long hold-off on request
    initial begin : result_sink
        logic seen_flip;
        int   k;
        seen_flip = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_flip != seen_flip) begin
                seen_flip = hold_flip;
                // keep ready low while the sender keeps pushing, so the block stalls its input
                for (k = 0; k < HOLD_CYCLES; k++) begin
                    i_ready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // offers one request and returns at the edge where the transaction happens;
    // valid stays high so a back-to-back request needs no second assignment
    task automatic send_req(input logic [2:0] req, input logic [31:0] val);
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= req;
        i_value    <= val;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
    endtask

    // sender goes quiet until every predicted result has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 9) < 7)
            return value_pool[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    // random traffic; stretches alternate between leaning toward fill and toward drain
    // so the store keeps swinging between empty and full
    task automatic run_random(input int n, input int tx_pct, input int rx_pct);
        int         k;
        int         r;
        logic       filling;
        logic [2:0] req;
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        for (k = 0; k < n; k++) begin
            filling = ((k / BIAS_BLOCK) % 2) == 0;
            r = $urandom_range(0, 99);
            if (r < 5)
                req = $urandom_range(0, 1) ? REQ_NOP_LO : REQ_NOP_HI;
            else if (r < 30)
                req = $urandom_range(0, 1) ? REQ_CONTAINS : REQ_REMOVE;
            else if ((r < 85) == filling)
                req = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
            else
                req = $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
            send_req(req, pick_value());
        end
    endtask

    initial begin : stimulus
        logic [31:0] fill_vals [16];
        int          k;

        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hffff_ffff;
        for (k = 4; k < 8; k++)
            value_pool[k] = $urandom();

        for (k = 0; k < 16; k++)
            fill_vals[k] = 32'h0101_0101 * k + 32'h0f00_0000;
        fill_vals[0] = 32'h7fff_ffff;
        fill_vals[1] = 32'h8000_0000;
        fill_vals[2] = 32'h0000_0000;
        fill_vals[3] = 32'hffff_ffff;
        fill_vals[9] = 32'h0000_0000;  // duplicate of an earlier entry, further back

        // synchronous reset, held low from the start and then released
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rx_idle_pct <= 57;
        tx_idle_pct = 18;
        @(posedge i_clk);

        // empty store: pops report an error, searches find nothing, unused codes do nothing
        send_req(REQ_POP_FRONT, 32'h1234_5678);
        send_req(REQ_POP_BACK, 32'hdead_beef);
        send_req(REQ_CONTAINS, 32'h0000_0000);
        send_req(REQ_REMOVE, 32'h0000_0000);
        send_req(REQ_NOP_LO, 32'hffff_ffff);
        send_req(REQ_NOP_HI, 32'h8000_0000);

        // fill to the brim from both ends, extremes of the value field among the entries
        for (k = 0; k < 16; k++)
            send_req((k % 2 == 0) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, fill_vals[k]);

        // full store: both pushes are dropped
        send_req(REQ_PUSH_FRONT, 32'h5555_5555);
        send_req(REQ_PUSH_BACK, 32'haaaa_aaaa);

        // zero sits twice; removal takes the one nearer the front, out of the middle
        send_req(REQ_CONTAINS, 32'h0000_0000);
        send_req(REQ_REMOVE, 32'h0000_0000);
        send_req(REQ_REMOVE, 32'h1234_5678);
        send_req(REQ_POP_FRONT, 32'h0000_0000);
        send_req(REQ_POP_BACK, 32'h0000_0000);
        wait_drained();

        // sender busy, receiver sparse
        run_random(PHASE_ITEMS, 18, 57);
        wait_drained();

        // sender sparse, receiver busy
        run_random(PHASE_ITEMS, 57, 18);
        wait_drained();

        // no idling, opened by a long receiver hold-off against a steady sender
        hold_flip <= ~hold_flip;
        run_random(PHASE_ITEMS, 0, 0);
        wait_drained();

        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/dbt_pkg.sv
sv/dbt_cell.sv
sv/deque_bag_table.sv
tb/dbt_result_checker.sv
tb/testbench.sv
